@@ hw/rtl/mstsp_pkg.sv @@
package mstsp_pkg;

  localparam int MAX_STATES = 4;
  localparam int STATE_W = 2;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_DEPTH_LOG2 = $clog2(EXP_TABLE_DEPTH);
  localparam int RATE_W = 24;
  localparam int VEL_W = 24;
  localparam int ROW_W = MAX_STATES * RATE_W;
  localparam int KT_W = RATE_W + $clog2(MAX_STATES);
  localparam int UNI_W = 16;
  localparam int PROB_W = 17;
  localparam int CNT_W = 3;
  localparam int LEN_W = 24;
  localparam int TS_W = 16;

  // Q32 width of one table entry on the x axis
  localparam longint unsigned EXP_H = (64'd16 << 32) / EXP_TABLE_DEPTH;

  localparam logic [2:0] OP_WR_FREE_RATE = 3'd0;
  localparam logic [2:0] OP_WR_COLL_RATE = 3'd1;
  localparam logic [2:0] OP_WR_FREE_VEL  = 3'd2;
  localparam logic [2:0] OP_WR_COLL_VEL  = 3'd3;
  localparam logic [2:0] OP_STEP         = 3'd4;

  localparam logic [1:0] CFG_FREE_COUNT = 2'd0;
  localparam logic [1:0] CFG_COLL_COUNT = 2'd1;
  localparam logic [1:0] CFG_TIME_STEP  = 2'd2;
  localparam logic [1:0] CFG_SOMA       = 2'd3;

  typedef logic [PROB_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

  typedef logic [VEL_W-1:0] vel_row_t [MAX_STATES];

  // Step context captured when the word is accepted
  typedef struct packed {
    logic               step_ok;
    logic [STATE_W-1:0] cur;
    logic               coll;
    logic               regrow;
    logic [CNT_W-1:0]   n;
    logic [UNI_W-1:0]   ugate;
    logic [UNI_W-1:0]   upick;
  } step_t;

  typedef struct packed {
    logic [STATE_W-1:0] new_state;
    logic               new_collision;
    logic [VEL_W-1:0]   new_velocity;
    logic               velocity_valid;
    logic               state_changed;
    logic               regrown;
  } result_t;

  // Shift-and-subtract quotient, used only while the table is built
  function automatic longint unsigned div_elab(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // 1 - exp(-x) table over x in [0,16), Q1.16, built at elaboration
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t          rom;
    longint unsigned   term;
    longint unsigned   e;
    longint            r;
    longint unsigned   rnd;
    term = 64'd1 << 32;
    r = 64'sd1 << 32;
    e = 64'd1 << 32;
    for (int k = 1; k <= 20; k++) begin
      term = div_elab((term * EXP_H) >> 32, 64'(k));
      if ((k & 1) == 1) r = r - longint'(term);
      else r = r + longint'(term);
    end
    if (r < 0) r = 0;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      rnd = (e + 64'd32768) >> 16;
      rom[i] = PROB_W'(64'd65536 - rnd);
      e = (e * longint'(unsigned'(r))) >> 32;
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

@@ hw/rtl/mstsp_tables.sv @@
module mstsp_tables (
  input  logic                                 clk_i,
  input  logic                                 accept_i,
  input  logic [2:0]                           opcode_i,
  input  logic [mstsp_pkg::STATE_W-1:0]        row_i,
  input  logic [mstsp_pkg::STATE_W-1:0]        col_i,
  input  logic [mstsp_pkg::RATE_W-1:0]         value_i,
  input  logic [mstsp_pkg::STATE_W-1:0]        cur_i,
  input  logic                                 coll_i,
  output logic [mstsp_pkg::ROW_W-1:0]          rate_row_o,
  output mstsp_pkg::vel_row_t                  vel_row_o,
  output logic [mstsp_pkg::VEL_W-1:0]          vel_free0_o
);

  logic [mstsp_pkg::ROW_W-1:0] free_mem [mstsp_pkg::MAX_STATES];
  logic [mstsp_pkg::ROW_W-1:0] coll_mem [mstsp_pkg::MAX_STATES];
  mstsp_pkg::vel_row_t         free_vel_q;
  mstsp_pkg::vel_row_t         coll_vel_q;

  // Writes and the read of a step share the acceptance edge, one word each
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      if (opcode_i == mstsp_pkg::OP_WR_FREE_RATE) begin
        free_mem[row_i][col_i*mstsp_pkg::RATE_W +: mstsp_pkg::RATE_W] <= value_i;
      end
      if (opcode_i == mstsp_pkg::OP_WR_COLL_RATE) begin
        coll_mem[row_i][col_i*mstsp_pkg::RATE_W +: mstsp_pkg::RATE_W] <= value_i;
      end
      if (opcode_i == mstsp_pkg::OP_WR_FREE_VEL) free_vel_q[row_i] <= value_i;
      if (opcode_i == mstsp_pkg::OP_WR_COLL_VEL) coll_vel_q[row_i] <= value_i;
      rate_row_o  <= coll_i ? coll_mem[cur_i] : free_mem[cur_i];
      vel_row_o   <= coll_i ? coll_vel_q : free_vel_q;
      vel_free0_o <= free_vel_q[0];
    end
  end

endmodule

@@ hw/rtl/mstsp_core.sv @@
module mstsp_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 s1_valid_i,
  input  mstsp_pkg::step_t                     s1_i,
  input  logic [mstsp_pkg::ROW_W-1:0]          rate_row_i,
  input  mstsp_pkg::vel_row_t                  vel_row_i,
  input  logic [mstsp_pkg::VEL_W-1:0]          vel_free0_i,
  input  logic [mstsp_pkg::TS_W-1:0]           time_step_i,
  output logic                                 out_valid_o,
  output mstsp_pkg::result_t                   out_o
);

  localparam int PK_W = mstsp_pkg::KT_W + mstsp_pkg::UNI_W;
  localparam int EXP_SHIFT = 20 - mstsp_pkg::EXP_DEPTH_LOG2;

  typedef logic [mstsp_pkg::KT_W-1:0] cum_t [mstsp_pkg::MAX_STATES];

  // Stage 2: prefix sums of outgoing rates
  logic                      s2_valid_q;
  mstsp_pkg::step_t          s2_q;
  cum_t                      s2_cum_q, s2_cum_d;
  mstsp_pkg::vel_row_t       s2_vel_q;
  logic [mstsp_pkg::VEL_W-1:0] s2_v0_q;

  // Stage 3: products
  logic                      s3_valid_q;
  mstsp_pkg::step_t          s3_q;
  cum_t                      s3_cum_q;
  mstsp_pkg::vel_row_t       s3_vel_q;
  logic [mstsp_pkg::VEL_W-1:0] s3_v0_q;
  logic [mstsp_pkg::KT_W-1:0]  s3_x_q, s3_x_d;
  logic [PK_W-1:0]             s3_pk_q, s3_pk_d;
  logic [mstsp_pkg::KT_W+mstsp_pkg::TS_W-1:0] prod_x;

  mstsp_pkg::result_t        res_d;
  logic [mstsp_pkg::KT_W-1:0]  xi;
  logic                        sat;
  logic [mstsp_pkg::PROB_W-1:0] p;
  logic                        fire;
  logic                        picked;
  logic [mstsp_pkg::STATE_W-1:0] next;

  always_comb begin
    logic [mstsp_pkg::KT_W-1:0] acc;
    acc = '0;
    for (int j = 0; j < mstsp_pkg::MAX_STATES; j++) begin
      if ((j < int'(s1_i.n)) && (j != int'(s1_i.cur))) begin
        acc = acc + mstsp_pkg::KT_W'(rate_row_i[j*mstsp_pkg::RATE_W +: mstsp_pkg::RATE_W]);
      end
      s2_cum_d[j] = acc;
    end
  end

  always_comb begin
    prod_x  = s2_cum_q[mstsp_pkg::MAX_STATES-1] * time_step_i;
    s3_x_d  = prod_x[mstsp_pkg::TS_W +: mstsp_pkg::KT_W];
    s3_pk_d = PK_W'(s2_q.upick) * PK_W'(s2_cum_q[mstsp_pkg::MAX_STATES-1]);
  end

  always_comb begin
    xi   = s3_x_q >> EXP_SHIFT;
    sat  = (xi >> mstsp_pkg::EXP_DEPTH_LOG2) != '0;
    p    = sat ? mstsp_pkg::PROB_W'(65536)
               : mstsp_pkg::EXP_ROM[xi[mstsp_pkg::EXP_DEPTH_LOG2-1:0]];
    fire = s3_q.step_ok && (mstsp_pkg::PROB_W'(s3_q.ugate) < p);
    picked = 1'b0;
    next   = s3_q.cur;
    for (int j = 0; j < mstsp_pkg::MAX_STATES; j++) begin
      if (!picked && (j < int'(s3_q.n)) && (j != int'(s3_q.cur)) &&
          (s3_pk_q < {s3_cum_q[j], {mstsp_pkg::UNI_W{1'b0}}})) begin
        picked = 1'b1;
        next   = mstsp_pkg::STATE_W'(j);
      end
    end
    res_d.new_state      = s3_q.cur;
    res_d.new_collision  = s3_q.coll;
    res_d.new_velocity   = '0;
    res_d.velocity_valid = 1'b0;
    res_d.state_changed  = 1'b0;
    res_d.regrown        = 1'b0;
    if (fire) begin
      res_d.new_state      = next;
      res_d.new_velocity   = s3_vel_q[next];
      res_d.velocity_valid = 1'b1;
      res_d.state_changed  = picked;
      if (s3_q.regrow) begin
        res_d.new_state     = '0;
        res_d.new_collision = 1'b0;
        res_d.new_velocity  = s3_v0_q;
        res_d.regrown       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q  <= s1_valid_i;
      s3_valid_q  <= s2_valid_q;
      out_valid_o <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_q     <= s1_i;
      s2_cum_q <= s2_cum_d;
      s2_vel_q <= vel_row_i;
      s2_v0_q  <= vel_free0_i;
      s3_q     <= s2_q;
      s3_cum_q <= s2_cum_q;
      s3_vel_q <= s2_vel_q;
      s3_v0_q  <= s2_v0_q;
      s3_x_q   <= s3_x_d;
      s3_pk_q  <= s3_pk_d;
      out_o    <= res_d;
    end
  end

endmodule

@@ hw/rtl/markov_state_transition_sampler_top.sv @@
// Markov jump sampler: one word in, one result word out, four stages deep.
// The result word is registered through stage 1, stage 2, stage 3 and the
// output register in turn.
// Throughput: one word per cycle while the output is taken; the whole pipeline
// holds while the output register waits.
// Reset: control and configuration registers reset; the rate and velocity
// tables hold no defined value until written.
module markov_state_transition_sampler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // row_index[1:0], col_index[3:2], table_value[27:4], current_state[30:29],
  // in_collision[31], is_initial[32], branch_length[56:33],
  // uniform_gate[72:57], uniform_pick[88:73], zero fill above
  input  logic [95:0] s_axis_tdata,
  // opcode[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // new_state[1:0], new_collision[2], new_velocity[26:3], velocity_valid[27],
  // state_changed[28], regrown[29], zero fill above
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [23:0] cfg_data_i
);

  logic [mstsp_pkg::CNT_W-1:0] free_cnt_q;
  logic [mstsp_pkg::CNT_W-1:0] coll_cnt_q;
  logic [mstsp_pkg::TS_W-1:0]  time_step_q;
  logic [mstsp_pkg::LEN_W-1:0] soma_q;

  logic                        adv;
  logic                        accept;
  logic                        out_valid;
  mstsp_pkg::result_t          res;

  // Unpacked input fields
  logic [2:0]                     opcode;
  logic [mstsp_pkg::STATE_W-1:0]  row_idx;
  logic [mstsp_pkg::STATE_W-1:0]  col_idx;
  logic [mstsp_pkg::RATE_W-1:0]   value;
  logic [mstsp_pkg::STATE_W-1:0]  cur;
  logic                           coll;
  logic                           init;
  logic [mstsp_pkg::LEN_W-1:0]    len;

  logic [mstsp_pkg::CNT_W-1:0]    n_raw;
  logic [mstsp_pkg::CNT_W-1:0]    n_sat;
  mstsp_pkg::step_t               s1_d, s1_q;
  logic                           s1_valid_q;
  logic [mstsp_pkg::ROW_W-1:0]    rate_row;
  mstsp_pkg::vel_row_t            vel_row;
  logic [mstsp_pkg::VEL_W-1:0]    vel_free0;

  assign cfg_ready_o = 1'b1;

  // Advance everything together unless a finished word is still waiting
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  assign opcode  = s_axis_tuser;
  assign row_idx = s_axis_tdata[1:0];
  assign col_idx = s_axis_tdata[3:2];
  assign value   = s_axis_tdata[27:4];
  assign cur     = s_axis_tdata[30:29];
  assign coll    = s_axis_tdata[31];
  assign init    = s_axis_tdata[32];
  assign len     = s_axis_tdata[56:33];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_cnt_q  <= 3'd3;
      coll_cnt_q  <= 3'd2;
      time_step_q <= 16'd655;
      soma_q      <= 24'd2560;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        mstsp_pkg::CFG_FREE_COUNT: free_cnt_q  <= cfg_data_i[2:0];
        mstsp_pkg::CFG_COLL_COUNT: coll_cnt_q  <= cfg_data_i[2:0];
        mstsp_pkg::CFG_TIME_STEP:  time_step_q <= cfg_data_i[15:0];
        mstsp_pkg::CFG_SOMA:       soma_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the state count and check the present state against it
  always_comb begin
    n_raw = coll ? coll_cnt_q : free_cnt_q;
    n_sat = (int'(n_raw) > mstsp_pkg::MAX_STATES) ?
            mstsp_pkg::CNT_W'(mstsp_pkg::MAX_STATES) : n_raw;
    s1_d.step_ok = (opcode == mstsp_pkg::OP_STEP) && (n_sat > 3'd1) &&
                   (mstsp_pkg::CNT_W'(cur) < n_sat);
    s1_d.cur     = cur;
    s1_d.coll    = coll;
    s1_d.regrow  = init && (len < soma_q);
    s1_d.n       = n_sat;
    s1_d.ugate   = s_axis_tdata[72:57];
    s1_d.upick   = s_axis_tdata[88:73];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) s1_q <= s1_d;
  end

  mstsp_tables u_tables (
    .clk_i       (clk_i),
    .accept_i    (accept),
    .opcode_i    (opcode),
    .row_i       (row_idx),
    .col_i       (col_idx),
    .value_i     (value),
    .cur_i       (cur),
    .coll_i      (coll),
    .rate_row_o  (rate_row),
    .vel_row_o   (vel_row),
    .vel_free0_o (vel_free0)
  );

  mstsp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .s1_valid_i  (s1_valid_q),
    .s1_i        (s1_q),
    .rate_row_i  (rate_row),
    .vel_row_i   (vel_row),
    .vel_free0_i (vel_free0),
    .time_step_i (time_step_q),
    .out_valid_o (out_valid),
    .out_o       (res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, res.regrown, res.state_changed, res.velocity_valid,
                          res.new_velocity, res.new_collision, res.new_state};

endmodule

@@ dv/markov_state_transition_sampler_checker.sv @@
module markov_state_transition_sampler_checker
  import mstsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [23:0] cfg_data_i,
  output int          mismatch_o,
  output int          pending_o,
  output int          fired_o
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [16:0]       fire_prob [EXP_TABLE_DEPTH];
  logic [2:0]        free_cnt, coll_cnt;
  logic [15:0]       dt;
  logic [23:0]       soma;
  logic [23:0]       free_rate [MAX_STATES*MAX_STATES];
  logic [23:0]       coll_rate [MAX_STATES*MAX_STATES];
  logic [23:0]       free_vel [MAX_STATES];
  logic [23:0]       coll_vel [MAX_STATES];
  result_t           jump_q [$];

  // 1 - exp(-x) over [0,16), from a truncated Taylor sum of the per-entry decay
  initial begin
    longint unsigned h, term, e;
    longint          r;
    h = (64'd16 << 32) / EXP_TABLE_DEPTH;
    term = 64'd1 << 32;
    r = 64'sd1 << 32;
    e = 64'd1 << 32;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * h) >> 32) / k;
      r = (k % 2) ? r - longint'(term) : r + longint'(term);
    end
    if (r < 0) r = 0;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      fire_prob[i] = 17'(64'd65536 - ((e + 64'd32768) >> 16));
      e = (e * unsigned'(r)) >> 32;
    end
  end

  // Apply a word to the shadow tables and return the jump it should produce
  function automatic result_t predict_jump(logic [2:0] op, logic [95:0] d);
    result_t         res;
    logic [1:0]      row, col, cur, nxt;
    logic [23:0]     val, len;
    logic            coll, init, picked;
    longint unsigned ugate, upick, kt, cum, x, idx, p, rate_j;
    int              n;
    row = d[1:0];
    col = d[3:2];
    val = d[27:4];
    cur = d[30:29];
    coll = d[31];
    init = d[32];
    len = d[56:33];
    ugate = d[72:57];
    upick = d[88:73];
    res = '0;
    res.new_state = cur;
    res.new_collision = coll;
    case (op)
      OP_WR_FREE_RATE: free_rate[row*MAX_STATES+col] = val;
      OP_WR_COLL_RATE: coll_rate[row*MAX_STATES+col] = val;
      OP_WR_FREE_VEL:  free_vel[row] = val;
      OP_WR_COLL_VEL:  coll_vel[row] = val;
      default: ;
    endcase
    if (op != OP_STEP) return res;
    n = coll ? coll_cnt : free_cnt;
    if (n > MAX_STATES) n = MAX_STATES;
    if (n <= 1 || cur >= n) return res;
    kt = 0;
    for (int j = 0; j < n; j++)
      if (j != cur) kt += coll ? coll_rate[cur*MAX_STATES+j] : free_rate[cur*MAX_STATES+j];
    x = (kt * dt) >> 16;
    idx = (x * EXP_TABLE_DEPTH) >> 20;
    p = (idx >= EXP_TABLE_DEPTH) ? 65536 : fire_prob[idx];
    if (ugate >= p) return res;
    // walk the cumulative rates instead of dividing by kt
    nxt = cur;
    picked = 1'b0;
    cum = 0;
    for (int j = 0; j < n; j++) begin
      if (j != cur && !picked) begin
        rate_j = coll ? coll_rate[cur*MAX_STATES+j] : free_rate[cur*MAX_STATES+j];
        cum += rate_j;
        if (upick * kt < (cum << 16)) begin
          nxt = j;
          picked = 1'b1;
        end
      end
    end
    res.new_state = nxt;
    res.new_velocity = coll ? coll_vel[nxt] : free_vel[nxt];
    res.velocity_valid = 1'b1;
    res.state_changed = picked;
    if (init && len < soma) begin
      res.new_state = '0;
      res.new_collision = 1'b0;
      res.new_velocity = free_vel[0];
      res.regrown = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want, got;
    if (!rst_ni) begin
      free_cnt <= 3'd3;
      coll_cnt <= 3'd2;
      dt <= 16'd655;
      soma <= 24'd2560;
      mismatch_o <= 0;
      fired_o <= 0;
      jump_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.new_state = m_axis_tdata[1:0];
        got.new_collision = m_axis_tdata[2];
        got.new_velocity = m_axis_tdata[26:3];
        got.velocity_valid = m_axis_tdata[27];
        got.state_changed = m_axis_tdata[28];
        got.regrown = m_axis_tdata[29];
        if (jump_q.size() == 0) begin
          mismatch_o <= mismatch_o + 1;
          if (mismatch_o < 10) $display("%t: unexpected result word %h", $realtime, m_axis_tdata);
        end else begin
          want = jump_q.pop_front();
          if (want.velocity_valid) fired_o <= fired_o + 1;
          if (got !== want) begin
            mismatch_o <= mismatch_o + 1;
            if (mismatch_o < 10)
              $display("%t: result mismatch state %0d/%0d coll %0d/%0d vel %h/%h vv %0d/%0d chg %0d/%0d regrow %0d/%0d (exp/act)",
                       $realtime, want.new_state, got.new_state, want.new_collision,
                       got.new_collision, want.new_velocity, got.new_velocity,
                       want.velocity_valid, got.velocity_valid, want.state_changed,
                       got.state_changed, want.regrown, got.regrown);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        jump_q = {jump_q, predict_jump(s_axis_tuser, s_axis_tdata)};
      if (cfg_valid_i && cfg_ready_o)
        case (cfg_addr_i)
          CFG_FREE_COUNT: free_cnt <= cfg_data_i[2:0];
          CFG_COLL_COUNT: coll_cnt <= cfg_data_i[2:0];
          CFG_TIME_STEP:  dt <= cfg_data_i[15:0];
          CFG_SOMA:       soma <= cfg_data_i;
          default: ;
        endcase
    end
  end

  assign pending_o = jump_q.size();

endmodule

@@ dv/markov_state_transition_sampler_top_tb.sv @@
module markov_state_transition_sampler_top_tb;
  import mstsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = OP_STEP;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i = CFG_FREE_COUNT;
  logic [23:0] cfg_data_i = '0;

  int  mismatches, pending, fired;
  int  cycles = 0;
  int  words_sent = 0;
  int  steps_sent = 0;
  int  cfg_writes = 0;
  bit  no_idle = 1'b0;

  always #5 clk_i = ~clk_i;

  markov_state_transition_sampler_top DUT (.*);

  markov_state_transition_sampler_checker u_checker (
    .*,
    .mismatch_o(mismatches),
    .pending_o (pending),
    .fired_o   (fired)
  );

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("markov_state_transition_sampler_top_tb NOT OK");
      $finish;
    end
  end

  // Result side: drop ready at random, with a probability of 6 in 100, unless in the no-idle phase
  always @(negedge clk_i)
    if (rst_ni) m_axis_tready = no_idle || ($urandom_range(99) >= 6);

  // Present one word and hold it until taken; valid stays high across back-to-back words
  task automatic send_word(logic [2:0] op, logic [95:0] d);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 6) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
    if (op == OP_STEP) steps_sent++;
  endtask

  // Drop valid so the pipeline can empty
  task automatic go_quiet();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Write a register only once every result is home and the pipe has drained
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    go_quiet();
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_addr_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_writes++;
  endtask

  task automatic set_regs(logic [2:0] nf, logic [2:0] nc, logic [15:0] dt, logic [23:0] rad);
    write_reg(CFG_FREE_COUNT, 24'(nf));
    write_reg(CFG_COLL_COUNT, 24'(nc));
    write_reg(CFG_TIME_STEP, 24'(dt));
    write_reg(CFG_SOMA, rad);
  endtask

  // Pack the slave word, first field in the lowest bits
  function automatic logic [95:0] pack_word(logic [1:0] row, logic [1:0] col, logic [24:0] val,
                                            logic [1:0] cur, logic coll, logic init,
                                            logic [23:0] len, logic [15:0] ug, logic [15:0] up);
    return {7'd0, up, ug, len, init, coll, cur, val, col, row};
  endfunction

  // Rates spread over many magnitudes so both rare and certain jumps occur
  function automatic logic [24:0] rand_rate();
    logic [24:0] v;
    v = 25'($urandom_range(24'hFFFFFF) >> $urandom_range(24));
    if ($urandom_range(9) == 0) v = '0;
    if ($urandom_range(15) == 0) v = {1'b1, 24'hFFFFFF};
    return v;
  endfunction

  // Velocities cover positive and negative; the upper bit is sign extension only in the negative branch
  function automatic logic [24:0] rand_vel();
    return $urandom_range(1) ? 25'($urandom_range(24'hFFFFFF))
                             : {2'b11, 23'($urandom_range(23'h7FFFFF))};
  endfunction

  function automatic logic [23:0] rand_len(logic [23:0] rad);
    case ($urandom_range(3))
      0: return 24'($urandom_range(24'hFFFFFF));
      1: return '0;
      2: return 24'hFFFFFF;
      default: return rad + 24'($urandom_range(6)) - 24'd3;
    endcase
  endfunction

  task automatic rand_write();
    logic [2:0] op;
    op = 3'($urandom_range(3));
    send_word(op, pack_word(2'($urandom), 2'($urandom),
                            (op <= OP_WR_COLL_RATE) ? rand_rate() : rand_vel(),
                            2'($urandom), 1'($urandom), 1'($urandom),
                            24'($urandom), 16'($urandom), 16'($urandom)));
  endtask

  task automatic rand_step(logic [23:0] rad);
    logic [15:0] ug, up;
    ug = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom);
    up = ($urandom_range(7) == 0) ? 16'h0000 : 16'($urandom);
    send_word(OP_STEP, pack_word(2'($urandom), 2'($urandom), 25'($urandom), 2'($urandom),
                                 1'($urandom), 1'($urandom), rand_len(rad), ug, up));
  endtask

  // Fill every table entry so no step ever reads an unwritten one
  task automatic load_tables();
    for (int op = 0; op < 2; op++)
      for (int r = 0; r < MAX_STATES; r++)
        for (int c = 0; c < MAX_STATES; c++)
          send_word(3'(op), pack_word(2'(r), 2'(c), rand_rate(), '0, 0, 0, '0, '0, '0));
    for (int r = 0; r < MAX_STATES; r++) begin
      send_word(OP_WR_FREE_VEL, pack_word(2'(r), '0, rand_vel(), '0, 0, 0, '0, '0, '0));
      send_word(OP_WR_COLL_VEL, pack_word(2'(r), '0, rand_vel(), '0, 0, 0, '0, '0, '0));
    end
  endtask

  logic [2:0]  ph_free [6] = '{3'd3, 3'd4, 3'd0, 3'd7, 3'd2, 3'd4};
  logic [2:0]  ph_coll [6] = '{3'd2, 3'd4, 3'd1, 3'd5, 3'd3, 3'd6};
  logic [15:0] ph_dt   [6] = '{16'd655, 16'hFFFF, 16'd0, 16'd4000, 16'd20000, 16'd90};
  logic [23:0] ph_rad  [6] = '{24'd2560, 24'hFFFFFF, 24'd0, 24'd70000, 24'd2560, 24'd1};

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    load_tables();

    // Directed: extremes of the gate and the pick, regrowth both ways, unused opcodes
    send_word(OP_STEP, pack_word('0, '0, '0, 2'd0, 0, 0, 24'hFFFFFF, 16'h0000, 16'h0000));
    send_word(OP_STEP, pack_word('0, '0, '0, 2'd1, 0, 0, 24'hFFFFFF, 16'h0000, 16'hFFFF));
    send_word(OP_STEP, pack_word('0, '0, '0, 2'd2, 0, 1, 24'd0, 16'h0000, 16'h8000));
    send_word(OP_STEP, pack_word('0, '0, '0, 2'd1, 1, 1, 24'hFFFFFF, 16'h0000, 16'h1234));
    send_word(OP_STEP, pack_word('0, '0, '0, 2'd0, 1, 1, 24'd2559, 16'h0000, 16'hFFFF));
    send_word(OP_STEP, pack_word('0, '0, '0, 2'd3, 0, 0, 24'd0, 16'h0000, 16'h0000));
    send_word(OP_STEP, pack_word('0, '0, '0, 2'd2, 1, 0, 24'd0, 16'h0000, 16'h0000));
    send_word(OP_STEP, pack_word('0, '0, '0, 2'd0, 0, 0, 24'd0, 16'hFFFF, 16'h0000));
    for (int op = 5; op < 8; op++)
      send_word(3'(op), pack_word(2'd3, 2'd3, {1'b1, 24'hFFFFFF}, 2'd3, 1, 1, 24'hFFFFFF,
                                  16'hFFFF, 16'hFFFF));
    // An all-zero rate row never fires
    for (int c = 0; c < MAX_STATES; c++)
      send_word(OP_WR_FREE_RATE, pack_word(2'd1, 2'(c), '0, '0, 0, 0, '0, '0, '0));
    send_word(OP_STEP, pack_word('0, '0, '0, 2'd1, 0, 0, 24'hFFFFFF, 16'h0000, 16'h0000));
    send_word(OP_WR_FREE_RATE, pack_word(2'd1, 2'd0, {1'b1, 24'hFFFFFF}, '0, 0, 0, '0, '0, '0));
    send_word(OP_STEP, pack_word('0, '0, '0, 2'd1, 0, 0, 24'hFFFFFF, 16'hFFFE, 16'hFFFF));

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      set_regs(ph_free[ph], ph_coll[ph], ph_dt[ph], ph_rad[ph]);
      no_idle = (ph == 3);
      for (int i = 0; i < 180; i++) begin
        case ($urandom_range(99)) inside
          [0:14]:  rand_write();
          [15:16]: send_word(3'($urandom_range(7, 5)), 96'({$urandom, $urandom, $urandom}));
          default: rand_step(ph_rad[ph]);
        endcase
      end
      no_idle = 1'b0;
    end

    go_quiet();
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("run: %0d words (%0d steps, %0d fired) across %0d register writes and 6 settings",
             words_sent, steps_sent, fired, cfg_writes);
    if (mismatches == 0) begin
      $display("markov_state_transition_sampler_top_tb OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("markov_state_transition_sampler_top_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mstsp_pkg.sv
hw/rtl/mstsp_tables.sv
hw/rtl/mstsp_core.sv
hw/rtl/markov_state_transition_sampler_top.sv
dv/markov_state_transition_sampler_checker.sv
dv/markov_state_transition_sampler_top_tb.sv
